// ===== hdl/tlt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlt_pkg: shared constants, types and microcode for the tremolo core
// Field widths, fixed-point scaling, control word layout and the step program.
// ----------------------------------------------------------------------------
`default_nettype none

package tlt_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_WIDTH  = 17;

    localparam int DEPTH_W     = 17;
    localparam int QUARTER_W   = 16;
    localparam int INV_W       = 25;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 25;

    localparam int DEPTH_ONE     = 65536;
    localparam int RATIO_ONE     = 1 << 24;
    localparam int QUARTER_RESET = 12000;
    localparam int INV_RESET     = 1398;
    localparam int RATIO_SHIFT   = 24;
    localparam int GAIN_SHIFT    = 16;
    localparam int RATIO_W       = 26;   // signed, holds +-2^24
    localparam int GAIN_W        = 18;   // signed, holds +-2^16

    localparam int MUL_A_W = (COUNT_WIDTH > GAIN_W) ? COUNT_WIDTH : GAIN_W;
    localparam int MUL_B_W = (SAMPLE_WIDTH > RATIO_W) ? SAMPLE_WIDTH : RATIO_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int CMP_W   = ((COUNT_WIDTH > QUARTER_W) ? COUNT_WIDTH : QUARTER_W) + 2;

    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_QUARTER = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_INVERSE = CFG_INDEX_W'(2);

    localparam int N_STEPS = 4;
    localparam int STEP_W  = 2;

    localparam logic [STEP_W-1:0] STEP_IDLE  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_RATIO = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_GAIN  = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_OUT   = STEP_W'(3);

    typedef enum logic [1:0] {
        MUL_LFO,
        MUL_DEPTH,
        MUL_SAMPLE
    } t_mul_sel;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_XFER,
        COND_OUT_FREE
    } t_cond;

    // one microcode word
    typedef struct packed {
        t_cond             cond;
        logic [STEP_W-1:0] target;
        t_mul_sel          mul_sel;
        logic              take_in;
        logic              ld_ratio;
        logic              ld_gain;
        logic              ld_out;
        logic              lfo_step;
    } t_ucode;

    // decoded controls to the datapath and top level; the load and step strobes are condition-gated
    typedef struct packed {
        logic     in_ready;
        t_mul_sel mul_sel;
        logic     ld_x;
        logic     ld_ratio;
        logic     ld_gain;
        logic     ld_out;
        logic     lfo_step;
    } t_ctrl;

    typedef struct packed {
        logic in_xfer;
        logic out_free;
    } t_status;

    localparam t_ucode UCODE [N_STEPS] = '{
        '{cond: COND_IN_XFER,  target: STEP_RATIO, mul_sel: MUL_LFO,
          take_in: 1'b1, ld_ratio: 1'b0, ld_gain: 1'b0, ld_out: 1'b0, lfo_step: 1'b0},
        '{cond: COND_ALWAYS,   target: STEP_GAIN,  mul_sel: MUL_LFO,
          take_in: 1'b0, ld_ratio: 1'b1, ld_gain: 1'b0, ld_out: 1'b0, lfo_step: 1'b0},
        '{cond: COND_ALWAYS,   target: STEP_OUT,   mul_sel: MUL_DEPTH,
          take_in: 1'b0, ld_ratio: 1'b0, ld_gain: 1'b1, ld_out: 1'b0, lfo_step: 1'b0},
        '{cond: COND_OUT_FREE, target: STEP_IDLE,  mul_sel: MUL_SAMPLE,
          take_in: 1'b0, ld_ratio: 1'b0, ld_gain: 1'b0, ld_out: 1'b1, lfo_step: 1'b1}
    };

endpackage

`default_nettype wire

// ===== hdl/tlt_sequencer.sv =====
// ----------------------------------------------------------------------------
// tlt_sequencer: step counter and microcode ROM
// Fetches one control word per step and advances or holds on its condition.
// ----------------------------------------------------------------------------
`default_nettype none

module tlt_sequencer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tlt_pkg::t_status i_status,
    output tlt_pkg::t_ctrl       o_ctrl
);

    logic [tlt_pkg::STEP_W-1:0] r_step;
    logic [tlt_pkg::STEP_W-1:0] n_step;
    tlt_pkg::t_ucode            uc;
    logic                       fire;

    assign uc = tlt_pkg::UCODE[r_step];

    always_comb begin
        unique case (uc.cond)
            tlt_pkg::COND_ALWAYS:   fire = 1'b1;
            tlt_pkg::COND_IN_XFER:  fire = i_status.in_xfer;
            tlt_pkg::COND_OUT_FREE: fire = i_status.out_free;
            default:                fire = 1'b0;
        endcase
    end

    assign n_step = fire ? uc.target : r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tlt_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        o_ctrl.in_ready = uc.take_in;
        o_ctrl.mul_sel  = uc.mul_sel;
        o_ctrl.ld_x     = uc.take_in & fire;
        o_ctrl.ld_ratio = uc.ld_ratio & fire;
        o_ctrl.ld_gain  = uc.ld_gain & fire;
        o_ctrl.ld_out   = uc.ld_out & fire;
        o_ctrl.lfo_step = uc.lfo_step & fire;
    end

endmodule

`default_nettype wire

// ===== hdl/tlt_datapath.sv =====
// ----------------------------------------------------------------------------
// tlt_datapath: shared multiplier, gain pipeline registers and triangle LFO
// Ratio, gain and output each take one pass through the single multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module tlt_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tlt_pkg::t_ctrl                      i_ctrl,
    input  wire logic signed [tlt_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic [tlt_pkg::DEPTH_W-1:0]         i_depth,
    input  wire logic [tlt_pkg::QUARTER_W-1:0]       i_quarter,
    input  wire logic [tlt_pkg::INV_W-1:0]           i_inverse,
    input  wire logic                                i_clamp,
    input  wire logic [tlt_pkg::QUARTER_W-1:0]       i_clamp_q,
    output logic signed [tlt_pkg::SAMPLE_WIDTH-1:0]  o_result
);

    localparam int PW  = tlt_pkg::PROD_W;
    localparam int CW  = tlt_pkg::CMP_W;
    localparam int NW  = tlt_pkg::COUNT_WIDTH;
    localparam int SW  = tlt_pkg::SAMPLE_WIDTH;

    localparam logic signed [PW-1:0] RAT_HI = PW'(tlt_pkg::RATIO_ONE);
    localparam logic signed [PW-1:0] RAT_LO = -RAT_HI;
    localparam logic signed [PW-1:0] Y_HI   = PW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] Y_LO   = -Y_HI - PW'(1);

    logic signed [SW-1:0]                  r_x;
    logic signed [tlt_pkg::RATIO_W-1:0]    r_ratio;
    logic signed [tlt_pkg::GAIN_W-1:0]     r_gain;
    logic signed [NW-1:0]                  r_pos;
    logic                                  r_falling;

    logic signed [tlt_pkg::MUL_A_W-1:0]    mul_a;
    logic signed [tlt_pkg::MUL_B_W-1:0]    mul_b;
    logic signed [PW-1:0]                  prod;
    logic signed [PW-1:0]                  prod_dr;
    logic signed [PW-1:0]                  prod_y;
    logic signed [tlt_pkg::RATIO_W-1:0]    n_ratio;
    logic signed [tlt_pkg::GAIN_W-1:0]     n_gain;
    logic signed [tlt_pkg::GAIN_W-1:0]     gain_base;

    logic signed [CW-1:0]                  pos_ext;
    logic signed [CW-1:0]                  q_ext;
    logic signed [CW-1:0]                  cq_ext;
    logic                                  n_falling;
    logic signed [NW-1:0]                  n_pos;

    always_comb begin
        case (i_ctrl.mul_sel)
            tlt_pkg::MUL_LFO: begin
                mul_a = tlt_pkg::MUL_A_W'(r_pos);
                mul_b = $signed(tlt_pkg::MUL_B_W'(i_inverse));
            end
            tlt_pkg::MUL_DEPTH: begin
                mul_a = $signed(tlt_pkg::MUL_A_W'(i_depth));
                mul_b = tlt_pkg::MUL_B_W'(r_ratio);
            end
            tlt_pkg::MUL_SAMPLE: begin
                mul_a = tlt_pkg::MUL_A_W'(r_gain);
                mul_b = tlt_pkg::MUL_B_W'(r_x);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // ratio saturates at +-1.0 (an inconsistent reciprocal can overshoot)
    always_comb begin
        if (prod > RAT_HI) begin
            n_ratio = tlt_pkg::RATIO_W'(RAT_HI);
        end else if (prod < RAT_LO) begin
            n_ratio = tlt_pkg::RATIO_W'(RAT_LO);
        end else begin
            n_ratio = tlt_pkg::RATIO_W'(prod);
        end
    end

    // arithmetic shifts round toward minus infinity
    assign prod_dr   = prod >>> tlt_pkg::RATIO_SHIFT;
    assign gain_base = tlt_pkg::GAIN_W'(tlt_pkg::DEPTH_ONE) - $signed(tlt_pkg::GAIN_W'(i_depth));
    assign n_gain    = gain_base + tlt_pkg::GAIN_W'(prod_dr);

    assign prod_y = prod >>> tlt_pkg::GAIN_SHIFT;

    always_comb begin
        if (prod_y > Y_HI) begin
            o_result = SW'(Y_HI);
        end else if (prod_y < Y_LO) begin
            o_result = SW'(Y_LO);
        end else begin
            o_result = SW'(prod_y);
        end
    end

    // triangle LFO: turn at either bound, then move by one
    assign pos_ext = CW'(r_pos);
    assign q_ext   = $signed(CW'(i_quarter));
    assign cq_ext  = $signed(CW'(i_clamp_q));

    always_comb begin
        n_falling = r_falling;
        if (pos_ext >= q_ext) begin
            n_falling = 1'b1;
        end
        if (pos_ext <= -q_ext) begin
            n_falling = 1'b0;
        end
        n_pos = n_falling ? r_pos - NW'(1) : r_pos + NW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_falling <= 1'b0;
        end else if (i_clamp) begin
            if (pos_ext > cq_ext) begin
                r_pos <= NW'(cq_ext);
            end else if (pos_ext < -cq_ext) begin
                r_pos <= NW'(-cq_ext);
            end
        end else if (i_ctrl.lfo_step) begin
            r_pos     <= n_pos;
            r_falling <= n_falling;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_x) begin
            r_x <= i_sample;
        end
        if (i_ctrl.ld_ratio) begin
            r_ratio <= n_ratio;
        end
        if (i_ctrl.ld_gain) begin
            r_gain <= n_gain;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/triangle_lfo_tremolo_core.sv =====
// ----------------------------------------------------------------------------
// triangle_lfo_tremolo_core: tremolo with triangle LFO amplitude modulation
// Config registers, output register and the sequencer/datapath pair.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     i_in_valid/o_in_stall  i_sample_in  (16b signed)
//  output    o_out_valid/i_out_stall o_sample_out (16b signed)
//  config    i_cfg_valid/o_cfg_ready i_cfg_index (2b), i_cfg_data (25b)
//
//  Each sample is first transferred in, then makes three passes
//  through the single shared multiplier (LFO ratio, gain, scaled sample).
//  The result sits in an output register; the next sample is taken in while
//  it waits. The last step holds only while that register is full and stalled.
//  Reset: depth 0, quarter period 12000, reciprocal 1398, LFO at zero rising.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_lfo_tremolo_core (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_stall,
    input  wire logic signed [tlt_pkg::SAMPLE_WIDTH-1:0]  i_sample_in,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_stall,
    output logic signed [tlt_pkg::SAMPLE_WIDTH-1:0]       o_sample_out,
    input  wire logic                                     i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  wire logic [tlt_pkg::CFG_INDEX_W-1:0]          i_cfg_index,
    input  wire logic [tlt_pkg::CFG_DATA_W-1:0]           i_cfg_data
);

    logic [tlt_pkg::DEPTH_W-1:0]           r_depth;
    logic [tlt_pkg::QUARTER_W-1:0]         r_quarter;
    logic [tlt_pkg::INV_W-1:0]             r_inverse;
    logic                                  r_out_valid;
    logic signed [tlt_pkg::SAMPLE_WIDTH-1:0] r_out_data;

    tlt_pkg::t_ctrl                        ctrl;
    tlt_pkg::t_status                      status;
    logic signed [tlt_pkg::SAMPLE_WIDTH-1:0] result;

    logic                                  cfg_xfer;
    logic [tlt_pkg::DEPTH_W-1:0]           cfg_depth;
    logic [tlt_pkg::QUARTER_W-1:0]         cfg_quarter;
    logic                                  clamp;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid & o_cfg_ready;

    assign cfg_depth   = tlt_pkg::DEPTH_W'(i_cfg_data);
    assign cfg_quarter = (tlt_pkg::QUARTER_W'(i_cfg_data) == '0)
                       ? tlt_pkg::QUARTER_W'(1) : tlt_pkg::QUARTER_W'(i_cfg_data);
    assign clamp       = cfg_xfer && (i_cfg_index == tlt_pkg::REG_QUARTER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_quarter <= tlt_pkg::QUARTER_W'(tlt_pkg::QUARTER_RESET);
            r_inverse <= tlt_pkg::INV_W'(tlt_pkg::INV_RESET);
        end else if (cfg_xfer) begin
            if (i_cfg_index == tlt_pkg::REG_DEPTH) begin
                r_depth <= (cfg_depth > tlt_pkg::DEPTH_W'(tlt_pkg::DEPTH_ONE))
                         ? tlt_pkg::DEPTH_W'(tlt_pkg::DEPTH_ONE) : cfg_depth;
            end else if (i_cfg_index == tlt_pkg::REG_QUARTER) begin
                r_quarter <= cfg_quarter;
            end else if (i_cfg_index == tlt_pkg::REG_INVERSE) begin
                r_inverse <= tlt_pkg::INV_W'(i_cfg_data);
            end
        end
    end

    assign o_in_stall      = ~ctrl.in_ready;
    assign status.in_xfer  = i_in_valid & ctrl.in_ready;
    assign status.out_free = ~r_out_valid | ~i_out_stall;

    tlt_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    tlt_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_sample  (i_sample_in),
        .i_depth   (r_depth),
        .i_quarter (r_quarter),
        .i_inverse (r_inverse),
        .i_clamp   (clamp),
        .i_clamp_q (cfg_quarter),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.ld_out) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

endmodule

`default_nettype wire

// ===== hdl/tlt_checker.sv =====
// ----------------------------------------------------------------------------
// tlt_checker: port-level checks for the tremolo core
// Reset, busy window after a transfer, and output register behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module tlt_checker (
    input wire logic                                    i_clk,
    input wire logic                                    i_rst_n,
    input wire logic                                    i_in_valid,
    input wire logic                                    o_in_stall,
    input wire logic                                    o_out_valid,
    input wire logic                                    i_out_stall,
    input wire logic signed [tlt_pkg::SAMPLE_WIDTH-1:0] o_sample_out
);

    logic in_xfer;
    assign in_xfer = i_in_valid & ~o_in_stall;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // three multiplier passes follow each input transfer
    a_busy_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("input taken during computation");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a computation");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled result changed");

endmodule

bind triangle_lfo_tremolo_core tlt_checker u_tlt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sample_out (o_sample_out)
);

`default_nettype wire
